>>> rtl/wir_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wir_pkg
// Shared constants for the wall intersect and reflect block.
// ----------------------------------------------------------------------------
package wir_pkg;

	// normal components carry two integer bits above the fraction
	localparam int NORM_EXTRA = 2;

	// per-lane saturation and parallel status at the output
	typedef struct packed {
		logic parallel;
		logic saturated;
	} flags_t;

endpackage
`default_nettype wire

>>> rtl/wir_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wir_in_if
// Input channel: two points, wall normal and wall offset per beat.
// ----------------------------------------------------------------------------
interface wir_in_if #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS = 16
) ();
	localparam int NW = FRAC_BITS + wir_pkg::NORM_EXTRA;

	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] ax;
	logic signed [COORD_WIDTH-1:0] ay;
	logic signed [COORD_WIDTH-1:0] az;
	logic signed [COORD_WIDTH-1:0] cx;
	logic signed [COORD_WIDTH-1:0] cy;
	logic signed [COORD_WIDTH-1:0] cz;
	logic signed [NW-1:0] nx;
	logic signed [NW-1:0] ny;
	logic signed [NW-1:0] nz;
	logic signed [COORD_WIDTH-1:0] wall_offset;

	modport source (output valid, ax, ay, az, cx, cy, cz, nx, ny, nz, wall_offset,
		input ready);
	modport sink (input valid, ax, ay, az, cx, cy, cz, nx, ny, nz, wall_offset,
		output ready);
endinterface
`default_nettype wire

>>> rtl/wir_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wir_out_if
// Output channel: hit point, reflected point and flags per beat.
// ----------------------------------------------------------------------------
interface wir_out_if #(
	parameter int COORD_WIDTH = 32
) ();
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] hit_x;
	logic signed [COORD_WIDTH-1:0] hit_y;
	logic signed [COORD_WIDTH-1:0] hit_z;
	logic signed [COORD_WIDTH-1:0] refl_x;
	logic signed [COORD_WIDTH-1:0] refl_y;
	logic signed [COORD_WIDTH-1:0] refl_z;
	logic parallel_flag;
	logic saturated_flag;

	modport source (output valid, hit_x, hit_y, hit_z, refl_x, refl_y, refl_z,
		parallel_flag, saturated_flag, input ready);
	modport sink (input valid, hit_x, hit_y, hit_z, refl_x, refl_y, refl_z,
		parallel_flag, saturated_flag, output ready);
endinterface
`default_nettype wire

>>> rtl/wall_intersect_and_reflect.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wall_intersect_and_reflect
// Line/plane hit point and mirrored point for a move from A to C.
// ----------------------------------------------------------------------------
// Usage:
//  item   (sink)   one beat per move: A, C, unit normal N, wall offset.
//  result (source) one beat per item: hit point B, reflected point D,
//                  parallel and saturation flags, in order.
// Throughput: one beat per cycle while result is not stalled. The t
// divider retires one quotient bit per stage; NNW = COORD_WIDTH +
// 2*FRAC_BITS + 5 is its numerator and quotient magnitude width.
// Both wall candidates t are divided in parallel and selected afterward;
// three axis lanes form B and the (B-C).N terms, a merge stage sums them,
// and three more lanes form D.
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When the receiver stalls with a beat on result, the whole pipeline holds
// and item.ready drops in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module wall_intersect_and_reflect #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	wir_in_if.sink   item,
	wir_out_if.source result
);
	localparam int CW = COORD_WIDTH;
	localparam int FB = FRAC_BITS;
	localparam int NW = FB + wir_pkg::NORM_EXTRA;
	localparam int PW = CW + NW + 2;
	localparam int DW = PW + 1;
	localparam int NUMW = PW + 1;
	localparam int NNW = NUMW + FB;
	localparam int QW = NNW + 1;
	localparam int TW = CW + FB + 3;
	localparam int CTXW = 3 * CW + 3 * NW + 3 * (CW + 1);
	localparam int SPW = CW + NW + 3;
	localparam int LAT = 7;
	localparam logic signed [QW-1:0] T_ONE = QW'(1) <<< FB;
	localparam logic signed [QW-1:0] T_MAX = QW'(1) <<< (CW + FB + 1);

	logic en;
	logic acc;

	logic signed [CW-1:0] av [3];
	logic signed [CW-1:0] cv [3];
	logic signed [NW-1:0] nv [3];
	logic signed [CW:0]   dacv [3];
	logic [CTXW-1:0]      ctx_in;

	logic                    vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [CW+NW-1:0] an_s1 [3];
	logic signed [CW+NW-1:0] cn_s1 [3];
	logic signed [CW-1:0]    w_s1, w_s2;
	logic [CTXW-1:0]         ctx_s1, ctx_s2, ctx_s3, ctx_s4;
	logic signed [PW-1:0]    sa_s2, sc_s2;
	logic signed [DW-1:0]    den_s3;
	logic signed [NUMW-1:0]  num1_s3, num2_s3;
	logic                    par_s3, par_s4;
	logic signed [CW+FB-1:0] wsh;

	logic                 dv_valid;
	logic signed [QW-1:0] q1, q2;
	logic [CTXW-1:0]      ctx_dv;
	logic                 par_dv;
	logic                 sel;
	logic signed [QW-1:0] tsel, tclamp;
	logic signed [TW-1:0] t_s4;

	logic vld_pipe_q [LAT];
	logic par_pipe_q [LAT];

	logic signed [CW-1:0]   lc [3];
	logic signed [NW-1:0]   ln [3];
	logic signed [CW:0]     ldac [3];
	logic signed [CW+NW:0]  cbn [3];
	logic signed [CW-1:0]   hb [3];
	logic                   hsat [3];
	logic signed [CW-1:0]   hc [3];
	logic signed [NW-1:0]   hn [3];
	logic signed [SPW-1:0]  psum_s5;
	logic signed [CW-1:0]   hit [3];
	logic signed [CW-1:0]   refl [3];
	wir_pkg::flags_t        lflags [3];

	assign en = !result.valid || result.ready;
	assign acc = item.valid && en;
	assign item.ready = en;

	always_comb begin
		av[0] = item.ax;
		av[1] = item.ay;
		av[2] = item.az;
		cv[0] = item.cx;
		cv[1] = item.cy;
		cv[2] = item.cz;
		nv[0] = item.nx;
		nv[1] = item.ny;
		nv[2] = item.nz;
		for (int i = 0; i < 3; i++) begin
			dacv[i] = (CW+1)'(av[i]) - (CW+1)'(cv[i]);
		end
		ctx_in = {cv[0], cv[1], cv[2], nv[0], nv[1], nv[2], dacv[0], dacv[1], dacv[2]};
		wsh = $signed({w_s2, {FB{1'b0}}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			for (int i = 0; i < LAT; i++) begin
				vld_pipe_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s1 <= acc;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= dv_valid;
			vld_pipe_q[0] <= vld_s4;
			for (int i = 1; i < LAT; i++) begin
				vld_pipe_q[i] <= vld_pipe_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				an_s1[i] <= av[i] * nv[i];
				cn_s1[i] <= cv[i] * nv[i];
			end
			w_s1 <= item.wall_offset;
			ctx_s1 <= ctx_in;

			sa_s2 <= PW'(an_s1[0]) + PW'(an_s1[1]) + PW'(an_s1[2]);
			sc_s2 <= PW'(cn_s1[0]) + PW'(cn_s1[1]) + PW'(cn_s1[2]);
			w_s2 <= w_s1;
			ctx_s2 <= ctx_s1;

			den_s3 <= DW'(sa_s2) - DW'(sc_s2);
			num1_s3 <= NUMW'(wsh) - NUMW'(sc_s2);
			num2_s3 <= -NUMW'(wsh) - NUMW'(sc_s2);
			par_s3 <= sa_s2 == sc_s2;
			ctx_s3 <= ctx_s2;

			t_s4 <= TW'(tclamp);
			ctx_s4 <= ctx_dv;
			par_s4 <= par_dv;

			par_pipe_q[0] <= par_s4;
			for (int i = 1; i < LAT; i++) begin
				par_pipe_q[i] <= par_pipe_q[i-1];
			end

			psum_s5 <= SPW'(cbn[0]) + SPW'(cbn[1]) + SPW'(cbn[2]);
		end
	end

	wir_div #(.NNW(NNW), .DDW(DW), .SW(CTXW)) u_div_near (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s3),
		.num      ($signed({num1_s3, {FB{1'b0}}})),
		.den      (den_s3),
		.side_in  (ctx_s3),
		.out_valid(dv_valid),
		.quot     (q1),
		.side_out (ctx_dv)
	);

	wir_div #(.NNW(NNW), .DDW(DW), .SW(1)) u_div_far (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s3),
		.num      ($signed({num2_s3, {FB{1'b0}}})),
		.den      (den_s3),
		.side_in  (par_s3),
		.out_valid(),
		.quot     (q2),
		.side_out (par_dv)
	);

	always_comb begin
		sel = (q1 < 0) || (q1 > T_ONE);
		tsel = sel ? q2 : q1;
		if (tsel > T_MAX) begin
			tclamp = T_MAX;
		end else if (tsel < -T_MAX) begin
			tclamp = -T_MAX;
		end else begin
			tclamp = tsel;
		end
		for (int i = 0; i < 3; i++) begin
			lc[i] = ctx_s4[CTXW-1-i*CW -: CW];
			ln[i] = ctx_s4[CTXW-3*CW-1-i*NW -: NW];
			ldac[i] = ctx_s4[3*(CW+1)-1-i*(CW+1) -: CW+1];
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_lane
		wir_hit_lane #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) u_hit (
			.clk  (clk),
			.en   (en),
			.t    (t_s4),
			.dac  (ldac[g]),
			.c    (lc[g]),
			.n    (ln[g]),
			.cbn  (cbn[g]),
			.b    (hb[g]),
			.sat  (hsat[g]),
			.c_out(hc[g]),
			.n_out(hn[g])
		);

		wir_refl_lane #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) u_refl (
			.clk    (clk),
			.en     (en),
			.psum   (psum_s5),
			.b      (hb[g]),
			.hit_sat(hsat[g]),
			.c      (hc[g]),
			.n      (hn[g]),
			.par    (par_pipe_q[LAT-2]),
			.hit    (hit[g]),
			.refl   (refl[g]),
			.flags  (lflags[g])
		);
	end

	assign result.valid = vld_pipe_q[LAT-1];
	assign result.hit_x = hit[0];
	assign result.hit_y = hit[1];
	assign result.hit_z = hit[2];
	assign result.refl_x = refl[0];
	assign result.refl_y = refl[1];
	assign result.refl_z = refl[2];
	assign result.parallel_flag = par_pipe_q[LAT-1];
	assign result.saturated_flag = lflags[0].saturated || lflags[1].saturated
		|| lflags[2].saturated;

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !item.ready)
		else $error("input taken while result stalled");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> vld_s1)
		else $error("accepted beat missing from first stage");

	a_parallel_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.parallel_flag |-> !result.saturated_flag)
		else $error("saturation reported on parallel line");

	a_parallel_same: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.parallel_flag |->
		(result.hit_x == result.refl_x) && (result.hit_y == result.refl_y)
		&& (result.hit_z == result.refl_z))
		else $error("parallel line with hit and reflected points apart");
endmodule
`default_nettype wire

>>> rtl/wir_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wir_div
// Pipelined signed divider, one quotient bit per stage, truncating.
// ----------------------------------------------------------------------------
module wir_div #(
	parameter int NNW = 69,
	parameter int DDW = 53,
	parameter int SW = 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  in_valid,
	input  wire logic signed [NNW-1:0] num,
	input  wire logic signed [DDW-1:0] den,
	input  wire logic [SW-1:0]         side_in,
	output logic                       out_valid,
	output logic signed [NNW:0]        quot,
	output logic [SW-1:0]              side_out
);
	logic [NNW-1:0] nabs;
	logic [DDW-1:0] dabs;
	logic           neg_in;

	logic [DDW-1:0] rem_q [NNW];
	logic [NNW-1:0] nsh_q [NNW];
	logic [NNW-1:0] quo_q [NNW];
	logic [DDW-1:0] dv_q  [NNW];
	logic           neg_q [NNW];
	logic [SW-1:0]  sd_q  [NNW];
	logic           vld_q [NNW];

	always_comb begin
		nabs = num[NNW-1] ? NNW'(-num) : NNW'(num);
		dabs = den[DDW-1] ? DDW'(-den) : DDW'(den);
		neg_in = num[NNW-1] ^ den[DDW-1];
	end

	for (genvar g = 0; g < NNW; g++) begin : g_stage
		logic [DDW-1:0] rp;
		logic [DDW-1:0] dp;
		logic [NNW-1:0] np;
		logic [NNW-1:0] qp;
		logic           ngp;
		logic [SW-1:0]  sp;
		logic           vp;
		logic [DDW:0]   rs;
		logic           ge;

		if (g == 0) begin : g_head
			assign rp = '0;
			assign dp = dabs;
			assign np = nabs;
			assign qp = '0;
			assign ngp = neg_in;
			assign sp = side_in;
			assign vp = in_valid;
		end else begin : g_body
			assign rp = rem_q[g-1];
			assign dp = dv_q[g-1];
			assign np = nsh_q[g-1];
			assign qp = quo_q[g-1];
			assign ngp = neg_q[g-1];
			assign sp = sd_q[g-1];
			assign vp = vld_q[g-1];
		end

		assign rs = {rp, np[NNW-1]};
		assign ge = rs >= {1'b0, dp};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[g] <= 1'b0;
			end else if (en) begin
				vld_q[g] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[g] <= ge ? DDW'(rs - {1'b0, dp}) : rs[DDW-1:0];
				nsh_q[g] <= np << 1;
				quo_q[g] <= {qp[NNW-2:0], ge};
				dv_q[g] <= dp;
				neg_q[g] <= ngp;
				sd_q[g] <= sp;
			end
		end
	end

	assign out_valid = vld_q[NNW-1];
	assign side_out = sd_q[NNW-1];
	assign quot = neg_q[NNW-1] ? -$signed({1'b0, quo_q[NNW-1]})
		: $signed({1'b0, quo_q[NNW-1]});
endmodule
`default_nettype wire

>>> rtl/wir_hit_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wir_hit_lane
// One axis: hit coordinate B = t*(A-C) + C, saturated, and (B-C)*N term.
// ----------------------------------------------------------------------------
module wir_hit_lane #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  en,
	input  wire logic signed [COORD_WIDTH+FRAC_BITS+2:0] t,
	input  wire logic signed [COORD_WIDTH:0]           dac,
	input  wire logic signed [COORD_WIDTH-1:0]         c,
	input  wire logic signed [FRAC_BITS+wir_pkg::NORM_EXTRA-1:0] n,
	output logic signed [COORD_WIDTH+FRAC_BITS+wir_pkg::NORM_EXTRA:0] cbn,
	output logic signed [COORD_WIDTH-1:0]              b,
	output logic                                       sat,
	output logic signed [COORD_WIDTH-1:0]              c_out,
	output logic signed [FRAC_BITS+wir_pkg::NORM_EXTRA-1:0] n_out
);
	localparam int CW = COORD_WIDTH;
	localparam int NW = FRAC_BITS + wir_pkg::NORM_EXTRA;
	localparam int TW = CW + FRAC_BITS + 3;
	localparam int K = TW / 2;
	localparam int PRW = TW + CW + 2;
	localparam int VW = PRW - FRAC_BITS + 1;

	logic signed [K+CW+1:0]    pl_s1;
	logic signed [TW-K+CW:0]   ph_s1;
	logic signed [CW-1:0]      c_s1, c_s2, c_s3, c_s4;
	logic signed [NW-1:0]      n_s1, n_s2, n_s3, n_s4;
	logic signed [PRW-1:0]     prod_s2;
	logic signed [CW-1:0]      b_s3, b_s4;
	logic                      sat_s3, sat_s4;
	logic signed [CW+NW:0]     cbn_s4;
	logic signed [VW-1:0]      vc;
	logic                      ovf;
	logic signed [CW:0]        cb;

	always_comb begin
		vc = VW'(prod_s2 >>> FRAC_BITS) + VW'(c_s2);
		ovf = !((&vc[VW-1:CW-1]) || (~|vc[VW-1:CW-1]));
		cb = (CW+1)'(b_s3) - (CW+1)'(c_s3);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1 <= $signed({1'b0, t[K-1:0]}) * dac;
			ph_s1 <= $signed(t[TW-1:K]) * dac;
			c_s1 <= c;
			n_s1 <= n;

			prod_s2 <= (PRW'(ph_s1) <<< K) + PRW'(pl_s1);
			c_s2 <= c_s1;
			n_s2 <= n_s1;

			b_s3 <= ovf ? (vc[VW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}})
				: vc[CW-1:0];
			sat_s3 <= ovf;
			c_s3 <= c_s2;
			n_s3 <= n_s2;

			cbn_s4 <= cb * n_s3;
			b_s4 <= b_s3;
			sat_s4 <= sat_s3;
			c_s4 <= c_s3;
			n_s4 <= n_s3;
		end
	end

	assign cbn = cbn_s4;
	assign b = b_s4;
	assign sat = sat_s4;
	assign c_out = c_s4;
	assign n_out = n_s4;
endmodule
`default_nettype wire

>>> rtl/wir_refl_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wir_refl_lane
// One axis: reflected coordinate D = 2*p*N + C, saturated, final output.
// ----------------------------------------------------------------------------
module wir_refl_lane #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic signed [COORD_WIDTH+FRAC_BITS+wir_pkg::NORM_EXTRA+2:0] psum,
	input  wire logic signed [COORD_WIDTH-1:0] b,
	input  wire logic                          hit_sat,
	input  wire logic signed [COORD_WIDTH-1:0] c,
	input  wire logic signed [FRAC_BITS+wir_pkg::NORM_EXTRA-1:0] n,
	input  wire logic                          par,
	output logic signed [COORD_WIDTH-1:0]      hit,
	output logic signed [COORD_WIDTH-1:0]      refl,
	output wir_pkg::flags_t                    flags
);
	localparam int CW = COORD_WIDTH;
	localparam int NW = FRAC_BITS + wir_pkg::NORM_EXTRA;
	localparam int SPW = CW + NW + 3;
	localparam int PPW = SPW - FRAC_BITS + 1;
	localparam int VDW = PPW + NW - FRAC_BITS + 1;

	logic signed [CW-1:0]     b_s1, b_s2, c_s1, c_s2, hit_s3, refl_s3;
	logic                     sat_s1, sat_s2, sat_s3;
	logic signed [NW-1:0]     n_s1;
	logic signed [PPW+NW-1:0] pn_s2;
	logic signed [PPW-1:0]    p;
	logic signed [VDW-1:0]    vd;
	logic                     ovf;
	logic signed [CW-1:0]     dsat;

	always_comb begin
		p = PPW'(psum >>> FRAC_BITS) <<< 1;
		vd = VDW'(pn_s2 >>> FRAC_BITS) + VDW'(c_s2);
		ovf = !((&vd[VDW-1:CW-1]) || (~|vd[VDW-1:CW-1]));
		dsat = ovf ? (vd[VDW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}})
			: vd[CW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s1 <= b;
			sat_s1 <= hit_sat;
			c_s1 <= c;
			n_s1 <= n;

			pn_s2 <= p * n_s1;
			b_s2 <= b_s1;
			sat_s2 <= sat_s1;
			c_s2 <= c_s1;

			hit_s3 <= par ? c_s2 : b_s2;
			refl_s3 <= par ? c_s2 : dsat;
			sat_s3 <= !par && (sat_s2 || ovf);
		end
	end

	assign hit = hit_s3;
	assign refl = refl_s3;
	assign flags.parallel = par;
	assign flags.saturated = sat_s3;
endmodule
`default_nettype wire

>>> tb/sv/wall_intersect_and_reflect_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wall_intersect_and_reflect_tb
// Checks the hit point, the reflected point and both flags against a
// 128-bit fixed-point model of the geometry. Directed moves cover the
// extremes, parallel moves, the mirror-wall path and saturation. Random moves
// follow, first under sender and receiver stalls and then with none.
// ----------------------------------------------------------------------------
module wall_intersect_and_reflect_tb;

	localparam int CW = 32;
	localparam int FB = 16;
	localparam int NW = FB + wir_pkg::NORM_EXTRA;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic signed [CW-1:0] ax, ay, az, cx, cy, cz, wall;
		logic signed [NW-1:0] nx, ny, nz;
	} move_t;

	typedef struct {
		logic signed [CW-1:0] hx, hy, hz, rx, ry, rz;
		logic par, sat;
	} bounce_t;

	logic clk;
	logic arst_n;
	bit failed;
	int idle_in;
	int idle_out;
	bounce_t bounce_q[$];

	wir_in_if #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) item_if ();
	wir_out_if #(.COORD_WIDTH(CW)) result_if ();

	wall_intersect_and_reflect #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_if),
		.result(result_if)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	initial begin
		#1_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic wide_t clamp_coord(wide_t v, ref logic sat);
		wide_t hi;
		wide_t lo;
		hi = (wide_t'(1) <<< (CW - 1)) - 1;
		lo = -(wide_t'(1) <<< (CW - 1));
		if (v > hi) begin
			sat = 1'b1;
			return hi;
		end
		if (v < lo) begin
			sat = 1'b1;
			return lo;
		end
		return v;
	endfunction

	function automatic bounce_t predict_bounce(move_t m);
		bounce_t r;
		wide_t a[3], c[3], n[3], b[3], d[3];
		wide_t w, sa, sc, den, t, tmax, p;
		logic sat;
		a[0] = m.ax; a[1] = m.ay; a[2] = m.az;
		c[0] = m.cx; c[1] = m.cy; c[2] = m.cz;
		n[0] = m.nx; n[1] = m.ny; n[2] = m.nz;
		w = wide_t'(m.wall) <<< FB;
		sa = a[0] * n[0] + a[1] * n[1] + a[2] * n[2];
		sc = c[0] * n[0] + c[1] * n[1] + c[2] * n[2];
		den = sa - sc;
		sat = 1'b0;
		r.par = (den == 0);
		if (r.par) begin
			b = c;
			d = c;
		end else begin
			t = ((w - sc) <<< FB) / den;
			if (t < 0 || t > (wide_t'(1) <<< FB))
				t = ((-w - sc) <<< FB) / den;
			tmax = wide_t'(1) <<< (CW + FB + 1);
			if (t > tmax) t = tmax;
			if (t < -tmax) t = -tmax;
			for (int i = 0; i < 3; i++)
				b[i] = clamp_coord(((t * (a[i] - c[i])) >>> FB) + c[i], sat);
			p = ((b[0] - c[0]) * n[0] + (b[1] - c[1]) * n[1] + (b[2] - c[2]) * n[2]) >>> FB;
			p = p <<< 1;
			for (int i = 0; i < 3; i++)
				d[i] = clamp_coord(((p * n[i]) >>> FB) + c[i], sat);
		end
		r.hx = b[0][CW-1:0]; r.hy = b[1][CW-1:0]; r.hz = b[2][CW-1:0];
		r.rx = d[0][CW-1:0]; r.ry = d[1][CW-1:0]; r.rz = d[2][CW-1:0];
		r.sat = sat;
		return r;
	endfunction

	task automatic send_move(move_t m);
		@(negedge clk);
		while ($urandom_range(99) < idle_in) begin
			item_if.valid <= 1'b0;
			@(negedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.ax <= m.ax; item_if.ay <= m.ay; item_if.az <= m.az;
		item_if.cx <= m.cx; item_if.cy <= m.cy; item_if.cz <= m.cz;
		item_if.nx <= m.nx; item_if.ny <= m.ny; item_if.nz <= m.nz;
		item_if.wall_offset <= m.wall;
		do @(posedge clk); while (!item_if.ready);
		bounce_q.push_back(predict_bounce(m));
	endtask

	function automatic move_t make_move(logic signed [CW-1:0] ax, ay, az, cx, cy, cz,
		logic signed [NW-1:0] nx, ny, nz, logic signed [CW-1:0] wall);
		move_t m;
		m.ax = ax; m.ay = ay; m.az = az; m.cx = cx; m.cy = cy; m.cz = cz;
		m.nx = nx; m.ny = ny; m.nz = nz; m.wall = wall;
		return m;
	endfunction

	always @(negedge clk)
		result_if.ready <= ($urandom_range(99) >= idle_out);

	task automatic check_field(string name, logic signed [63:0] exp_v,
		logic signed [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			failed = 1'b1;
		end
	endtask

	always @(posedge clk) begin
		bounce_t e;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (bounce_q.size() == 0) begin
				$error("result beat with nothing expected");
				failed = 1'b1;
			end else begin
				e = bounce_q.pop_front();
				check_field("hit_x", e.hx, result_if.hit_x);
				check_field("hit_y", e.hy, result_if.hit_y);
				check_field("hit_z", e.hz, result_if.hit_z);
				check_field("refl_x", e.rx, result_if.refl_x);
				check_field("refl_y", e.ry, result_if.refl_y);
				check_field("refl_z", e.rz, result_if.refl_z);
				check_field("parallel_flag", e.par, result_if.parallel_flag);
				check_field("saturated_flag", e.sat, result_if.saturated_flag);
			end
		end
	end

	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [NW-1:0] ONE = 1 <<< FB;

	task automatic test_extremes();
		send_move(make_move(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, ONE, ONE, ONE, CMAX));
		send_move(make_move(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, -ONE, -ONE, -ONE, CMIN));
		send_move(make_move(0, 0, 0, 32'sh0002_0000, 0, 0, ONE, 0, 0, 32'sh0001_0000));
		send_move(make_move(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_move(make_move(-1, -1, -1, 1, 1, 1, '1, '1, '1, -1));
		send_move(make_move(CMAX, 0, CMIN, 0, CMAX, 0, {1'b0, {(NW-1){1'b1}}},
			{1'b1, {(NW-1){1'b0}}}, ONE, 0));
	endtask

	task automatic test_parallel();
		send_move(make_move(32'sh0003_0000, 5, 7, 32'sh0003_0000, 9, -4, ONE, 0, 0, 32'sh0001_0000));
		send_move(make_move(1, 2, 3, 1, 2, 3, 0, ONE, 0, 0));
		send_move(make_move(CMAX, 2, 3, -5, 7, 9, 0, 0, 0, CMIN));
	endtask

	task automatic test_far_wall();
		// near wall outside [0,1], mirror wall selected
		send_move(make_move(0, 0, 32'sh0004_0000, 0, 0, -32'sh0008_0000, 0, 0, ONE,
			32'sh0010_0000));
		send_move(make_move(32'sh0000_8000, 1, 2, -32'sh0003_0000, 3, 4, ONE, 0, 0,
			32'sh0002_0000));
		send_move(make_move(0, 0, 0, 0, 5, 0, 0, ONE, 0, 32'sh0100_0000));
	endtask

	task automatic test_saturation();
		send_move(make_move(0, CMAX, 0, 1, CMIN, 0, ONE, 0, 0, CMAX));
		send_move(make_move(CMIN, 0, 0, CMAX, 0, 0, ONE, ONE, 0, 1));
		send_move(make_move(1, 2, 3, 0, 2, 3, ONE, 0, 0, CMIN));
	endtask

	function automatic logic signed [NW-1:0] rand_normal();
		case ($urandom_range(3))
			0: return $urandom_range(1) ? ONE : -ONE;
			1: return 0;
			2: return $signed(NW'($urandom_range(2 * ONE))) - ONE;
			default: return NW'($urandom);
		endcase
	endfunction

	task automatic test_random(int count);
		move_t m;
		int ax;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(4) == 0) begin
				m = make_move($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					rand_normal(), rand_normal(), rand_normal(), $urandom);
			end else begin
				// points and offset inside a box, normal mostly along one axis
				m = make_move($signed($urandom_range(2**21)) - 2**20,
					$signed($urandom_range(2**21)) - 2**20,
					$signed($urandom_range(2**21)) - 2**20,
					$signed($urandom_range(2**23)) - 2**22,
					$signed($urandom_range(2**23)) - 2**22,
					$signed($urandom_range(2**23)) - 2**22,
					0, 0, 0, $urandom_range(2**22));
				ax = $urandom_range(2);
				if (ax == 0) m.nx = $urandom_range(1) ? ONE : -ONE;
				if (ax == 1) m.ny = $urandom_range(1) ? ONE : -ONE;
				if (ax == 2) m.nz = $urandom_range(1) ? ONE : -ONE;
				if ($urandom_range(3) == 0) begin
					m.nx = rand_normal();
					m.ny = rand_normal();
					m.nz = rand_normal();
				end
			end
			send_move(m);
		end
	endtask

	initial begin
		int guard;
		failed = 1'b0;
		arst_n = 1'b0;
		item_if.valid = 1'b0;
		item_if.ax = '0; item_if.ay = '0; item_if.az = '0;
		item_if.cx = '0; item_if.cy = '0; item_if.cz = '0;
		item_if.nx = '0; item_if.ny = '0; item_if.nz = '0;
		item_if.wall_offset = '0;
		result_if.ready = 1'b0;
		idle_in = 22;
		idle_out = 71;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		test_extremes();
		test_parallel();
		test_far_wall();
		test_saturation();
		test_random(180);
		idle_in = 71;
		idle_out = 22;
		test_random(180);
		idle_in = 0;
		idle_out = 0;
		test_random(180);
		@(negedge clk);
		item_if.valid <= 1'b0;
		guard = 0;
		while (bounce_q.size() != 0 && guard < 50000) begin
			@(posedge clk);
			guard++;
		end
		repeat (120) @(posedge clk);
		if (!failed && bounce_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			if (bounce_q.size() != 0)
				$error("%0d results never arrived", bounce_q.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/wir_pkg.sv
rtl/wir_in_if.sv
rtl/wir_out_if.sv
rtl/wir_div.sv
rtl/wir_hit_lane.sv
rtl/wir_refl_lane.sv
rtl/wall_intersect_and_reflect.sv
tb/sv/wall_intersect_and_reflect_tb.sv
